// ===== rtl/btr_pkg.sv =====
// ============================================================================
// btr_pkg - shared types and constants of the bus telegram receiver
// Frame classes, reply codes, register indexes and the frame info record.
// ============================================================================
`default_nettype none

package btr_pkg;

    localparam int          HDR_LEN  = 5;
    localparam logic [7:0]  CRC_POLY = 8'h19;
    localparam logic [7:0]  POLL_BIT = 8'h80;
    localparam logic [7:0]  LEN_MAX  = 8'hFF;

    // configuration register indexes
    localparam logic [1:0]  CFG_OWN_ID       = 2'd0;
    localparam logic [1:0]  CFG_POLL_ENABLE  = 2'd1;
    localparam logic [1:0]  CFG_BROADCAST_ID = 2'd2;

    localparam logic [6:0]  OWN_ID_RESET       = 7'd11;
    localparam logic        POLL_ENABLE_RESET  = 1'b0;
    localparam logic [7:0]  BROADCAST_ID_RESET = 8'd0;

    typedef enum logic [2:0] {
        KIND_POLL_US   = 3'd0,
        KIND_SINGLE    = 3'd1,
        KIND_NOISE     = 3'd2,
        KIND_CRC_ERR   = 3'd3,
        KIND_TO_US     = 3'd4,
        KIND_BROADCAST = 3'd5,
        KIND_OTHER     = 3'd6
    } frame_kind_t;

    typedef enum logic [1:0] {
        REPLY_NONE     = 2'd0,
        REPLY_POLL_ACK = 2'd1,
        REPLY_SEND_TX  = 2'd2
    } reply_t;

    // frame view at the current byte: count including it, CRC before it,
    // header bytes with unreceived ones forced to zero
    typedef struct packed {
        logic [7:0]         length;
        logic [7:0]         crc;
        logic [4:0][7:0]    hdr;
    } frame_info_t;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] s;
        s = {crc[6:0], 1'b0};
        if (crc[7])
        begin
            s = s ^ CRC_POLY;
        end
        return s ^ b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/btr_frame_state.sv =====
// ============================================================================
// btr_frame_state - per-frame running state
// Holds running CRC, saturating byte count and captured header bytes.
// ============================================================================
`default_nettype none

module btr_frame_state (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               last_byte,
    output btr_pkg::frame_info_t    info
);

    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] length;
    logic [7:0] hdr_reg [btr_pkg::HDR_LEN];
    logic       hdr_wr;

    assign length = (count_reg == btr_pkg::LEN_MAX) ? count_reg : count_reg + 8'd1;
    assign hdr_wr = step && (count_reg < 8'(btr_pkg::HDR_LEN));

    always_comb
    begin
        crc_next   = crc_reg;
        count_next = count_reg;
        if (step)
        begin
            if (last_byte)
            begin
                crc_next   = 8'd0;
                count_next = 8'd0;
            end
            else
            begin
                crc_next   = btr_pkg::crc_step(crc_reg, rx_byte);
                count_next = length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= 8'd0;
            count_reg <= 8'd0;
        end
        else
        begin
            crc_reg   <= crc_next;
            count_reg <= count_next;
        end
    end

    // header store, no reset: entries above the count are masked below
    always_ff @(posedge clk)
    begin
        if (hdr_wr)
        begin
            hdr_reg[count_reg[2:0]] <= rx_byte;
        end
    end

    always_comb
    begin
        info.length = length;
        info.crc    = crc_reg;
        for (int i = 0; i < btr_pkg::HDR_LEN; i++)
        begin
            if (count_reg == 8'(i))
            begin
                info.hdr[i] = rx_byte;
            end
            else if (8'(i) < count_reg)
            begin
                info.hdr[i] = hdr_reg[i];
            end
            else
            begin
                info.hdr[i] = 8'd0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/btr_classify.sv =====
// ============================================================================
// btr_classify - frame classification at the closing byte
// Picks frame class and reply from length, CRC check and addresses.
// ============================================================================
`default_nettype none

module btr_classify (
    input  wire btr_pkg::frame_info_t   info,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   tx_pending,
    input  wire logic [6:0]             own_id,
    input  wire logic                   poll_enable,
    input  wire logic [7:0]             broadcast_id,
    output btr_pkg::frame_kind_t        kind,
    output btr_pkg::reply_t             reply
);

    always_comb
    begin
        reply = btr_pkg::REPLY_NONE;
        priority if (info.length == 8'd1)
        begin
            if (rx_byte == ({1'b0, own_id} | btr_pkg::POLL_BIT))
            begin
                kind = btr_pkg::KIND_POLL_US;
                if (tx_pending)
                begin
                    reply = btr_pkg::REPLY_SEND_TX;
                end
                else if (poll_enable)
                begin
                    reply = btr_pkg::REPLY_POLL_ACK;
                end
            end
            else
            begin
                kind = btr_pkg::KIND_SINGLE;
            end
        end
        else if (info.length < 8'(btr_pkg::HDR_LEN))
        begin
            kind = btr_pkg::KIND_NOISE;
        end
        else if (rx_byte != info.crc)
        begin
            kind = btr_pkg::KIND_CRC_ERR;
        end
        else if (info.hdr[1] == {1'b0, own_id})
        begin
            kind  = btr_pkg::KIND_TO_US;
            reply = btr_pkg::REPLY_POLL_ACK;
        end
        else if (info.hdr[1] == broadcast_id)
        begin
            kind = btr_pkg::KIND_BROADCAST;
        end
        else
        begin
            kind = btr_pkg::KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bus_telegram_receiver_core.sv =====
// ============================================================================
// bus_telegram_receiver_core - heating-bus telegram receive front end
// Byte stream in, one classified frame record out per closing byte.
// ============================================================================
// Path: a closing byte passes the input register, then the result register.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is free or being drained; only a closing byte waits on the single output slot.
// Reset: rst_n clears CRC, byte count, error total and both valid flags, and
//   loads own_id = 11, poll_enable = 0, broadcast_id = 0.
`default_nettype none

module bus_telegram_receiver_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // byte stream in
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [15:0]    s_tdata,   // [7:0] rx_byte, [8] tx_pending, zero pad
    input  wire logic           s_tlast,   // last_byte
    // frame records out
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [71:0]         m_tdata,   // [6:0] src_id, [14:7] dest_id,
                                           // [22:15] msg_type, [30:23] msg_offset,
                                           // [38:31] first_data, [46:39] frame_length,
                                           // [48:47] reply, [64:49] crc_error_count,
                                           // zero pad
    output logic [2:0]          m_tuser,   // frame_kind
    // register writes
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [7:0]     cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers; always ready, unknown indexes dropped
    // ------------------------------------------------------------------
    logic [6:0] own_id_reg;
    logic       poll_enable_reg;
    logic [7:0] broadcast_id_reg;
    logic       cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg       <= btr_pkg::OWN_ID_RESET;
            poll_enable_reg  <= btr_pkg::POLL_ENABLE_RESET;
            broadcast_id_reg <= btr_pkg::BROADCAST_ID_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg_index == btr_pkg::CFG_OWN_ID)
            begin
                own_id_reg <= cfg_data[6:0];
            end
            if (cfg_index == btr_pkg::CFG_POLL_ENABLE)
            begin
                poll_enable_reg <= cfg_data[0];
            end
            if (cfg_index == btr_pkg::CFG_BROADCAST_ID)
            begin
                broadcast_id_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // input register
    // A non-closing byte never needs the result slot, so it always moves
    // on; a closing byte waits until the result register can take it.
    // ------------------------------------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_pending_reg;
    logic       out_valid_reg;
    logic       in_adv;
    logic       in_step;
    logic       in_xfer;
    logic       load_result;

    assign in_adv      = !in_last_reg || !out_valid_reg || m_tready;
    assign in_step     = in_valid_reg && in_adv;
    assign s_tready    = !in_valid_reg || in_adv;
    assign in_xfer     = s_tvalid && s_tready;
    assign load_result = in_step && in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg    <= s_tdata[7:0];
            in_pending_reg <= s_tdata[8];
            in_last_reg    <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // frame state and classification
    // ------------------------------------------------------------------
    btr_pkg::frame_info_t   info;
    btr_pkg::frame_kind_t   kind;
    btr_pkg::reply_t        reply;

    btr_frame_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_step),
        .rx_byte   (in_byte_reg),
        .last_byte (in_last_reg),
        .info      (info)
    );

    btr_classify u_classify (
        .info         (info),
        .rx_byte      (in_byte_reg),
        .tx_pending   (in_pending_reg),
        .own_id       (own_id_reg),
        .poll_enable  (poll_enable_reg),
        .broadcast_id (broadcast_id_reg),
        .kind         (kind),
        .reply        (reply)
    );

    // bad CRC total, wraps at 16 bits
    logic [15:0] bad_crc_reg;
    logic [15:0] bad_crc_next;

    assign bad_crc_next = (load_result && (kind == btr_pkg::KIND_CRC_ERR))
                        ? bad_crc_reg + 16'd1 : bad_crc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_crc_reg <= 16'd0;
        end
        else
        begin
            bad_crc_reg <= bad_crc_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [71:0]            out_data_reg;
    btr_pkg::frame_kind_t   out_kind_reg;
    logic                   out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_kind_reg <= kind;
            out_data_reg <= {7'd0, bad_crc_next, reply, info.length,
                             info.hdr[4], info.hdr[3], info.hdr[2], info.hdr[1],
                             info.hdr[0][6:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_poll_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == btr_pkg::KIND_POLL_US)) |-> (m_tdata[46:39] == 8'd1))
        else $error("poll result with frame length other than one");

    a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[48:47] != btr_pkg::REPLY_NONE)) |->
        ((m_tuser == btr_pkg::KIND_POLL_US) || (m_tuser == btr_pkg::KIND_TO_US)))
        else $error("reply requested for a frame class that takes none");

    a_crc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (load_result && (kind == btr_pkg::KIND_CRC_ERR)) |=>
        (bad_crc_reg == $past(bad_crc_reg) + 16'd1))
        else $error("CRC error total not advanced on a CRC error frame");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |-> !load_result)
        else $error("result register overwritten while waiting");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> (u_state.info.length == 8'd1))
        else $error("byte count not cleared after a closing byte");

endmodule

`default_nettype wire
